@@ src/alfp_pkg.sv @@
`default_nettype none

package alfp_pkg;

   // Field widths fixed by the item format
   localparam int IDX_W   = 8;
   localparam int VALUE_W = 32;

   // Null node index / null link
   localparam logic [IDX_W-1:0] NULL_INDEX = 8'hFF;

   // Operation codes
   localparam logic [1:0] FUNC_ALLOC  = 2'd0;
   localparam logic [1:0] FUNC_WRITE  = 2'd1;
   localparam logic [1:0] FUNC_DELETE = 2'd2;
   localparam logic [1:0] FUNC_READ   = 2'd3;

   // Status codes
   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [1:0] STATUS_IGNORED = 2'd2;

   typedef struct packed {
      logic        [1:0]         func;
      logic signed [IDX_W-1:0]   node_index;
      logic signed [VALUE_W-1:0] write_value;
      logic signed [IDX_W-1:0]   write_link;
   } req_type;

   typedef struct packed {
      logic        [1:0]         status;
      logic signed [IDX_W-1:0]   result_index;
      logic signed [VALUE_W-1:0] read_value;
      logic signed [IDX_W-1:0]   read_link;
   } rsp_type;

   // Node store access from the sequencer
   typedef struct packed {
      logic               rd_en;
      logic [IDX_W-1:0]   rd_addr;
      logic               wr_value_en;
      logic               wr_link_en;
      logic [IDX_W-1:0]   wr_addr;
      logic [VALUE_W-1:0] wr_value;
      logic [IDX_W-1:0]   wr_link;
   } mem_req_type;

   // Node store read data, registered from the read and valid in the cycle after it
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [IDX_W-1:0]   link;
   } mem_rsp_type;

endpackage

`default_nettype wire

@@ src/alfp_node_mem.sv @@
`default_nettype none

module alfp_node_mem
   import alfp_pkg::*;
#(
   parameter int ENTRIES = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mem_req_type mem_req,
   output mem_rsp_type      mem_rsp
);

   // Only indices 0..127 are reachable through an 8-bit signed index
   localparam int DEPTH = (ENTRIES < 128) ? ENTRIES : 128;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [31:0] LAST_ENTRY = 32'(ENTRIES - 1);

   logic [VALUE_W-1:0] value_mem_ff [DEPTH];
   logic [IDX_W-1:0]   link_mem_ff  [DEPTH];
   logic [DEPTH-1:0]   link_valid_ff;

   logic [VALUE_W-1:0] rd_value_ff;
   logic [IDX_W-1:0]   rd_link_ff;
   logic               rd_hit_ff;
   logic [AW-1:0]      rd_addr_ff;

   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      wr_addr;
   logic [IDX_W-1:0]   reset_link;

   assign rd_addr = mem_req.rd_addr[AW-1:0];
   assign wr_addr = mem_req.wr_addr[AW-1:0];

   // Value store: written and read in the clocked block
   always_ff @(posedge clock) begin
      if (mem_req.wr_value_en) begin
         value_mem_ff[wr_addr] <= mem_req.wr_value;
      end
      if (mem_req.rd_en) begin
         rd_value_ff <= value_mem_ff[rd_addr];
      end
   end

   // Link store
   always_ff @(posedge clock) begin
      if (mem_req.wr_link_en) begin
         link_mem_ff[wr_addr] <= mem_req.wr_link;
      end
      if (mem_req.rd_en) begin
         rd_link_ff <= link_mem_ff[rd_addr];
         rd_hit_ff  <= link_valid_ff[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   // Mark link entries written since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         link_valid_ff <= '0;
      end else if (mem_req.wr_link_en) begin
         link_valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Unwritten link reads as the initial free chain: next entry, null at the end
   always_comb begin
      if (32'(rd_addr_ff) == LAST_ENTRY) begin
         reset_link = NULL_INDEX;
      end else begin
         reset_link = 8'(rd_addr_ff) + 8'd1;
      end
   end

   assign mem_rsp.value = rd_value_ff;
   assign mem_rsp.link  = rd_hit_ff ? rd_link_ff : reset_link;

endmodule

`default_nettype wire

@@ src/alfp_ctrl.sv @@
`default_nettype none

module alfp_ctrl
   import alfp_pkg::*;
#(
   parameter int ENTRIES = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_item,
   output logic             rsp_strobe,
   output rsp_type          rsp_item,
   output mem_req_type      mem_req,
   input  wire mem_rsp_type mem_rsp
);

   localparam logic [31:0] ENTRY_LIMIT = 32'(ENTRIES);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_COPY = 2'd2;
   localparam logic [1:0] ST_PUSH = 2'd3;

   logic [1:0]       state_ff, state_in;
   req_type          req_ff, req_in;
   logic [IDX_W-1:0] succ_ff, succ_in;
   logic [IDX_W-1:0] free_top_ff, free_top_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_strobe_ff, rsp_strobe_in;

   function automatic logic index_ok(input logic [IDX_W-1:0] idx);
      return !idx[IDX_W-1] && ({25'd0, idx[IDX_W-2:0]} < ENTRY_LIMIT);
   endfunction

   // Sequence one operation through the node store
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      succ_in       = succ_ff;
      free_top_in   = free_top_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      mem_req       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_item;
               state_in = ST_EXEC;
               if (req_item.func == FUNC_ALLOC) begin
                  mem_req.rd_addr = free_top_ff;
               end else begin
                  mem_req.rd_addr = req_item.node_index;
               end
               mem_req.rd_en = index_ok(mem_req.rd_addr);
            end
         end
         ST_EXEC: begin
            state_in                = ST_IDLE;
            rsp_strobe_in           = 1'b1;
            rsp_in.status           = STATUS_DONE;
            rsp_in.result_index     = NULL_INDEX;
            rsp_in.read_value       = '0;
            rsp_in.read_link        = NULL_INDEX;
            unique case (req_ff.func)
               FUNC_ALLOC: begin
                  if (index_ok(free_top_ff)) begin
                     rsp_in.result_index = free_top_ff;
                     free_top_in         = mem_rsp.link;
                  end else begin
                     rsp_in.status = STATUS_EMPTY;
                  end
               end
               FUNC_WRITE: begin
                  mem_req.wr_addr  = req_ff.node_index;
                  mem_req.wr_value = req_ff.write_value;
                  mem_req.wr_link  = req_ff.write_link;
                  if (index_ok(req_ff.node_index)) begin
                     mem_req.wr_value_en = 1'b1;
                     mem_req.wr_link_en  = 1'b1;
                  end
               end
               FUNC_DELETE: begin
                  if (!index_ok(req_ff.node_index) || !index_ok(mem_rsp.link)) begin
                     rsp_in.status = STATUS_IGNORED;
                  end else begin
                     // fetch the successor before overwriting the node
                     succ_in         = mem_rsp.link;
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = mem_rsp.link;
                     state_in        = ST_COPY;
                     rsp_strobe_in   = 1'b0;
                  end
               end
               FUNC_READ: begin
                  if (index_ok(req_ff.node_index)) begin
                     rsp_in.read_value = mem_rsp.value;
                     rsp_in.read_link  = mem_rsp.link;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_COPY: begin
            // copy the successor into the node
            mem_req.wr_value_en = 1'b1;
            mem_req.wr_link_en  = 1'b1;
            mem_req.wr_addr     = req_ff.node_index;
            mem_req.wr_value    = mem_rsp.value;
            mem_req.wr_link     = mem_rsp.link;
            state_in            = ST_PUSH;
         end
         ST_PUSH: begin
            // push the successor onto the free list
            mem_req.wr_link_en  = 1'b1;
            mem_req.wr_addr     = succ_ff;
            mem_req.wr_link     = free_top_ff;
            free_top_in         = succ_ff;
            state_in            = ST_IDLE;
            rsp_strobe_in       = 1'b1;
            rsp_in.status       = STATUS_DONE;
            rsp_in.result_index = NULL_INDEX;
            rsp_in.read_value   = '0;
            rsp_in.read_link    = NULL_INDEX;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_top_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_top_ff   <= free_top_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      succ_ff <= succ_in;
      rsp_ff  <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

@@ src/array_list_free_pool_unit.sv @@
`default_nettype none

// Node pool with a free list: ENTRIES nodes of a 32-bit value and an 8-bit link.
// Request channel: a beat is taken at a rising edge with start high and busy low;
// req_item carries the operation (allocate, write, delete, read) and its operands.
// Response channel: every request gives exactly one beat on rsp_item, marked by
// rsp_strobe for a single cycle; the receiver has no way to hold it off, so it
// must take every beat as it comes.
// Timing: allocate, write and read pass through the execute state, and their
// response is then registered before it is shown. A delete that acts also
// passes through the copy and push states, set by the dependent successor read
// and the two writes to the link store, which has a single write port. An
// ignored delete ends after the execute state, as the others do.
// busy drops in the cycle the response is shown, so the next request may
// overlap that beat.
// Reset: synchronous, active high. The free list starts as every node chained
// in order from node 0; link entries not written since reset read from this
// chain through per-entry valid bits, so there is no clearing pass and the
// block takes requests as soon as reset is released.

module array_list_free_pool_unit
   import alfp_pkg::*;
#(
   parameter int ENTRIES = 128
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_strobe,
   output rsp_type      rsp_item
);

   mem_req_type mem_req;
   mem_rsp_type mem_rsp;

   alfp_ctrl #(
      .ENTRIES (ENTRIES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .mem_req    (mem_req),
      .mem_rsp    (mem_rsp)
   );

   alfp_node_mem #(
      .ENTRIES (ENTRIES)
   ) u_node_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .mem_rsp (mem_rsp)
   );

`ifndef ASSERT_OFF
   // Reads and writes of the store never share a cycle
   assert property (@(posedge clock) disable iff (reset)
      mem_req.rd_en |-> !(mem_req.wr_value_en || mem_req.wr_link_en))
      else $error("node store read and write in the same cycle");

   // A taken request always moves the sequencer out of idle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken without starting work");

   // Response beats are never back to back
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back response beats");

   // A response only ends a period of work
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response beat without preceding work");
`endif

endmodule

`default_nettype wire
